[hw/rtl/atbt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atbt_pkg
// Shared constants and elaboration-time table functions for the tone bank.
// ----------------------------------------------------------------------------
package atbt_pkg;

  localparam int SAMPLE_RATE_DEF      = 48000;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_BITS_DEF       = 32;

  localparam int PARTIALS  = 9;
  localparam int GROUPS    = 3;
  localparam int LOOKUPS   = 2 * PARTIALS + 1;
  localparam int FADE_SLOT = 2 * PARTIALS;

  localparam int N_W      = 32;
  localparam int DUR_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [DUR_W-1:0] DURATION_RST = 16'd1200;
  localparam logic             REG_DURATION = 1'b0;

  localparam int QUEUE_DEPTH = 4;

  localparam int WEIGHT_W    = 17;
  localparam int TW_W        = 34;
  localparam int TERM_W      = 49;
  localparam int SUM_W       = 53;
  localparam int ROUND_SHIFT = 36;
  localparam int RES_W       = SUM_W - ROUND_SHIFT;

  localparam logic signed [SUM_W-1:0] ROUND_BIAS =
    {{(SUM_W - ROUND_SHIFT){1'b0}}, 1'b1, {(ROUND_SHIFT - 1){1'b0}}};

  localparam logic [63:0] PI_Q30           = 64'd3373259426;
  localparam logic [63:0] WEIGHT_RATIO_Q16 = 64'd62259;

  localparam logic [15:0] TONE_HZ [PARTIALS] = '{
    16'd174, 16'd285, 16'd396, 16'd417, 16'd528, 16'd639, 16'd741, 16'd852, 16'd964
  };

  // round(2^pb * num / den) mod 2^pb, restoring long division
  function automatic logic [63:0] frac_inc(input logic [63:0] num, input logic [63:0] den,
                                           input int pb);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      q = {q[62:0], 1'b0};
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    for (int b = 0; b < pb; b++) begin
      r = {r[62:0], 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    if ({r[62:0], 1'b0} >= den) begin
      q = q + 64'd1;
    end
    return q & ((64'd1 << pb) - 64'd1);
  endfunction

  // tremolo rate of partial k: 10^j / (9 * 13^j) Hz, j = 8 - k
  function automatic logic [63:0] trem_inc(input int k, input int sr, input int pb);
    logic [63:0] p10;
    logic [63:0] p13;
    p10 = 64'd1;
    p13 = 64'd1;
    for (int j = 0; j < PARTIALS - 1 - k; j++) begin
      p10 = p10 * 64'd10;
      p13 = p13 * 64'd13;
    end
    return frac_inc(p10, 64'd9 * p13 * 64'(sr), pb);
  endfunction

  function automatic logic [WEIGHT_W-1:0] weight_q16(input int k);
    logic [63:0] w;
    w = 64'd65536;
    for (int i = 0; i < k; i++) begin
      w = (w * WEIGHT_RATIO_Q16 + 64'd32768) >> 16;
    end
    return w[WEIGHT_W-1:0];
  endfunction

  // quarter-wave sine magnitude, Q15, q in 0..depth/4, depth = 2^lg
  function automatic logic [SAMPLE_W-2:0] sin_quarter(input int q, input int lg);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        v;
    x    = (64'(q) * 64'd2 * PI_Q30) >> lg;
    x2   = (x * x) >> 30;
    term = x;
    acc  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - signed'(term);
    if (acc < 0) begin
      acc = '0;
    end
    v = (unsigned'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SAMPLE_W-2:0];
  endfunction

endpackage

[hw/rtl/additive_tone_bank_with_tremolo_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// additive_tone_bank_with_tremolo_top
// Nine-partial additive tone bank with slow tremolo and a fade on the top tone.
//
// Input queue: write a 32-bit sample index with in_push while in_full is low.
// Result queue: while out_empty is low, out_audio_sample holds the oldest
// signed Q1.15 sample; out_pop takes it. One result per accepted index, in order.
// Throughput: one sample per cycle; the eight-stage sample pipeline takes a
// new index every cycle while the result side keeps popping.
// Stall: when the result is not taken the pipeline holds, the four-entry input
// queue keeps taking indexes until it fills, then in_full goes high.
// Config: APB register 0 (byte address 0) is duration_seconds. After reset
// and after each write, a bit-serial divider derives the fade rate (multiply,
// divide, round); in_full stays high meanwhile.
// Reset (rst_n low, synchronous) empties both queues, duration goes to 1200.
// ----------------------------------------------------------------------------
module additive_tone_bank_with_tremolo_top import atbt_pkg::*; #(
  parameter int SAMPLE_RATE      = SAMPLE_RATE_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = PHASE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [N_W-1:0]             in_sample_index,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [SAMPLE_W-1:0] out_audio_sample,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_AW-1:0]          paddr,
  input  logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready
);

  logic [PHASE_BITS-1:0] fade_inc;
  logic                  busy;
  logic                  q_valid;
  logic [N_W-1:0]        q_data;
  logic                  q_pop;

  atbt_cfg #(
    .SAMPLE_RATE (SAMPLE_RATE),
    .PHASE_BITS  (PHASE_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .fade_inc (fade_inc),
    .busy     (busy)
  );

  atbt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_sample_index (in_sample_index),
    .busy            (busy),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop)
  );

  atbt_back #(
    .SAMPLE_RATE      (SAMPLE_RATE),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .fade_inc         (fade_inc),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_audio_sample (out_audio_sample)
  );

`ifndef ASSERT_OFF
  a_write_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && (paddr[APB_AW-1] == REG_DURATION)) |=> in_full)
    else $error("input not blocked after duration write");

  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_full)
    else $error("input open while fade rate is recomputed");

  a_queue_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pipeline pulled from an empty queue");
`endif

endmodule

[hw/rtl/atbt_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atbt_cfg
// APB register file and serial divider for the fade phase increment.
// ----------------------------------------------------------------------------
module atbt_cfg import atbt_pkg::*; #(
  parameter int SAMPLE_RATE = SAMPLE_RATE_DEF,
  parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  output logic [PHASE_BITS-1:0] fade_inc,
  output logic                  busy
);

  localparam int TWO_SR_W = $clog2(2 * SAMPLE_RATE + 1);
  localparam int DEN_W    = DUR_W + TWO_SR_W;
  localparam int CNT_W    = $clog2(PHASE_BITS + 1);
  localparam logic [TWO_SR_W-1:0] TWO_SR = TWO_SR_W'(2 * SAMPLE_RATE);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_RND  = 2'd3;

  logic [1:0]            st_r, st_nxt;
  logic [DUR_W-1:0]      dur_r;
  logic [DEN_W-1:0]      den_r, den_nxt;
  logic [DEN_W:0]        rem_r, rem_nxt;
  logic [PHASE_BITS-1:0] quo_r, quo_nxt;
  logic [PHASE_BITS-1:0] inc_r, inc_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DUR_W-1:0]      dur_eff;
  logic [DEN_W:0]        rem_sh;
  logic                  wr_hit;

  assign pready  = 1'b1;
  assign wr_hit  = psel && penable && pwrite && pready && (paddr[APB_AW-1] == REG_DURATION);
  assign prdata  = (paddr[APB_AW-1] == REG_DURATION) ? APB_DW'(dur_r) : '0;
  assign dur_eff = (dur_r == '0) ? DUR_W'(1) : dur_r;
  assign rem_sh  = {rem_r[DEN_W-1:0], 1'b0};
  assign busy    = (st_r != ST_IDLE);
  assign fade_inc = inc_r;

  always_comb begin
    st_nxt  = st_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    inc_nxt = inc_r;
    unique case (st_r)
      ST_IDLE: begin
        st_nxt = ST_IDLE;
      end
      ST_MUL: begin
        den_nxt = DEN_W'(dur_eff) * DEN_W'(TWO_SR);
        rem_nxt = (DEN_W + 1)'(1);
        quo_nxt = '0;
        cnt_nxt = '0;
        st_nxt  = ST_DIV;
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = rem_sh - {1'b0, den_r};
          quo_nxt = {quo_r[PHASE_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[PHASE_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PHASE_BITS - 1)) begin
          st_nxt = ST_RND;
        end
      end
      ST_RND: begin
        inc_nxt = (rem_sh >= {1'b0, den_r}) ? quo_r + PHASE_BITS'(1) : quo_r;
        st_nxt  = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    if (wr_hit) begin
      st_nxt = ST_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_MUL;
      dur_r <= DURATION_RST;
    end else begin
      st_r <= st_nxt;
      if (wr_hit) begin
        dur_r <= pwdata[DUR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    inc_r <= inc_nxt;
  end

endmodule

[hw/rtl/atbt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atbt_front
// Input side: takes sample indexes and holds them in a short queue.
// ----------------------------------------------------------------------------
module atbt_front import atbt_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  logic [N_W-1:0] in_sample_index,
  input  logic           busy,
  output logic           q_valid,
  output logic [N_W-1:0] q_data,
  input  logic           q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [N_W-1:0]   mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push_ok;

  assign in_full = busy || (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push_ok && !q_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (!push_ok && q_pop) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= in_sample_index;
    end
  end

endmodule

[hw/rtl/atbt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atbt_back
// Sample pipeline: phases, sine lookups, weighting, tremolo, mix, saturation.
// ----------------------------------------------------------------------------
module atbt_back import atbt_pkg::*; #(
  parameter int SAMPLE_RATE      = SAMPLE_RATE_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = PHASE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  logic [N_W-1:0]             q_data,
  output logic                       q_pop,
  input  logic [PHASE_BITS-1:0]      fade_inc,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [SAMPLE_W-1:0] out_audio_sample
);

  localparam int LG  = $clog2(SINE_TABLE_DEPTH);
  localparam int QN  = SINE_TABLE_DEPTH / 4 + 1;
  localparam int QW  = $clog2(QN);
  localparam int PL  = PHASE_BITS / 2;
  localparam int PHW = PHASE_BITS - PL;
  localparam int NST = 8;

  localparam logic [LG-1:0] QUARTER = LG'(SINE_TABLE_DEPTH / 4);
  localparam logic [LG-1:0] HALF    = LG'(SINE_TABLE_DEPTH / 2);
  localparam logic [LG-1:0] THREE_Q = LG'(3 * SINE_TABLE_DEPTH / 4);

  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(32767);
  localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(-32768);

  function automatic logic [LG-1:0] lookup_offset(input int i);
    if (i < PARTIALS) begin
      return '0;
    end else if (i < FADE_SLOT) begin
      return THREE_Q;
    end
    return QUARTER;
  endfunction

  logic [PHASE_BITS-1:0] inc [LOOKUPS];
  logic [WEIGHT_W-1:0]   wgt [PARTIALS];
  logic [SAMPLE_W-2:0]   sine_rom [QN];

  for (genvar gk = 0; gk < PARTIALS; gk++) begin : g_const
    assign inc[gk]            = PHASE_BITS'(frac_inc(64'(TONE_HZ[gk]), 64'(SAMPLE_RATE),
                                                     PHASE_BITS));
    assign inc[PARTIALS + gk] = PHASE_BITS'(trem_inc(gk, SAMPLE_RATE, PHASE_BITS));
    assign wgt[gk]            = weight_q16(gk);
  end
  assign inc[FADE_SLOT] = fade_inc;

  for (genvar gi = 0; gi < QN; gi++) begin : g_rom
    assign sine_rom[gi] = sin_quarter(gi, LG);
  end

  logic           adv;
  logic [NST-1:0] vld_r;

  assign adv       = !vld_r[NST-1] || out_pop;
  assign q_pop     = adv && q_valid;
  assign out_empty = !vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], q_valid};
    end
  end

  // phase = n * inc mod 2^PHASE_BITS, split in two partial products
  logic [N_W+PL-1:0]     plo_c [LOOKUPS];
  logic [2*PHW-1:0]      phi_c [LOOKUPS];
  logic [PHASE_BITS-1:0] plo_r [LOOKUPS];
  logic [PHW-1:0]        phi_r [LOOKUPS];
  logic [PHASE_BITS-1:0] phase_c [LOOKUPS];
  logic [LG-1:0]         idx_r [LOOKUPS];

  always_comb begin
    for (int i = 0; i < LOOKUPS; i++) begin
      plo_c[i]   = (N_W + PL)'(q_data) * (N_W + PL)'(inc[i][PL-1:0]);
      phi_c[i]   = (2 * PHW)'(q_data[PHW-1:0]) * (2 * PHW)'(inc[i][PHASE_BITS-1:PL]);
      phase_c[i] = plo_r[i] + {phi_r[i], {PL{1'b0}}};
    end
  end

  // quarter-wave fold
  logic [QW-1:0]               fold_q [LOOKUPS];
  logic                        fold_neg [LOOKUPS];
  logic [SAMPLE_W-2:0]         mag_c [LOOKUPS];
  logic signed [SAMPLE_W-1:0]  sin_c [LOOKUPS];
  logic signed [SAMPLE_W-1:0]  sin_r [LOOKUPS];

  always_comb begin
    for (int i = 0; i < LOOKUPS; i++) begin
      if (idx_r[i] <= QUARTER) begin
        fold_q[i]   = QW'(idx_r[i]);
        fold_neg[i] = 1'b0;
      end else if (idx_r[i] <= THREE_Q) begin
        if (idx_r[i] > HALF) begin
          fold_q[i]   = QW'(idx_r[i] - HALF);
          fold_neg[i] = 1'b1;
        end else begin
          fold_q[i]   = QW'(HALF - idx_r[i]);
          fold_neg[i] = 1'b0;
        end
      end else begin
        fold_q[i]   = QW'(LG'(0) - idx_r[i]);
        fold_neg[i] = 1'b1;
      end
      mag_c[i] = sine_rom[fold_q[i]];
      sin_c[i] = fold_neg[i] ? SAMPLE_W'(0) - {1'b0, mag_c[i]} : {1'b0, mag_c[i]};
    end
  end

  // offset to unsigned Q16: s + 32768
  logic [SAMPLE_W-1:0]         lift_c [PARTIALS + 1];
  logic [2*SAMPLE_W-1:0]       tf_c;
  logic signed [TW_W-1:0]      tw_c [PARTIALS];
  logic signed [TW_W-1:0]      tw_r [PARTIALS];
  logic [SAMPLE_W-1:0]         trem_r [PARTIALS];
  logic signed [TERM_W-1:0]    prod_r [PARTIALS];
  logic signed [SUM_W-1:0]     sum3_r [GROUPS];
  logic signed [SUM_W-1:0]     total_r;
  logic signed [SUM_W-1:0]     rnd_c;
  logic signed [RES_W-1:0]     res_c;
  logic signed [RES_W-1:0]     sat_c;
  logic signed [SAMPLE_W-1:0]  out_r;

  always_comb begin
    for (int k = 0; k <= PARTIALS; k++) begin
      lift_c[k] = {~sin_r[PARTIALS + k][SAMPLE_W-1], sin_r[PARTIALS + k][SAMPLE_W-2:0]};
    end
    for (int k = 0; k < PARTIALS; k++) begin
      tw_c[k] = TW_W'(sin_r[k]) * TW_W'(signed'({1'b0, wgt[k]}));
    end
    tf_c = (2 * SAMPLE_W)'(lift_c[PARTIALS - 1]) * (2 * SAMPLE_W)'(lift_c[PARTIALS]);
  end

  always_comb begin
    rnd_c = total_r + ROUND_BIAS;
    res_c = rnd_c[SUM_W-1:ROUND_SHIFT];
    priority if (res_c > SAT_HI) begin
      sat_c = SAT_HI;
    end else if (res_c < SAT_LO) begin
      sat_c = SAT_LO;
    end else begin
      sat_c = res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LOOKUPS; i++) begin
        plo_r[i] <= plo_c[i][PHASE_BITS-1:0];
        phi_r[i] <= phi_c[i][PHW-1:0];
        idx_r[i] <= phase_c[i][PHASE_BITS-1 -: LG] + lookup_offset(i);
        sin_r[i] <= sin_c[i];
      end
      for (int k = 0; k < PARTIALS; k++) begin
        tw_r[k]   <= tw_c[k];
        prod_r[k] <= TERM_W'(tw_r[k]) * TERM_W'(signed'({1'b0, trem_r[k]}));
      end
      for (int k = 0; k < PARTIALS - 1; k++) begin
        trem_r[k] <= lift_c[k];
      end
      trem_r[PARTIALS-1] <= tf_c[2*SAMPLE_W-1:SAMPLE_W];
      for (int g = 0; g < GROUPS; g++) begin
        sum3_r[g] <= SUM_W'(prod_r[GROUPS*g]) + SUM_W'(prod_r[GROUPS*g + 1])
                   + SUM_W'(prod_r[GROUPS*g + 2]);
      end
      total_r <= sum3_r[0] + sum3_r[1] + sum3_r[2];
      out_r   <= sat_c[SAMPLE_W-1:0];
    end
  end

  assign out_audio_sample = out_r;

endmodule
